// File: src/ebalu_pkg.sv
`default_nettype none

package ebalu_pkg;

    // operation codes
    typedef enum logic [3:0] {
        OP_ADC = 4'd0,
        OP_AND = 4'd1,
        OP_ASL = 4'd2,
        OP_BIT = 4'd3,
        OP_CMP = 4'd4,
        OP_CPX = 4'd5,
        OP_CPY = 4'd6,
        OP_DEC = 4'd7,
        OP_EOR = 4'd8,
        OP_INC = 4'd9,
        OP_LD  = 4'd10,
        OP_LSR = 4'd11,
        OP_ORA = 4'd12,
        OP_ROL = 4'd13,
        OP_ROR = 4'd14,
        OP_SBC = 4'd15
    } ebalu_op_t;

    // request payload
    typedef struct packed {
        ebalu_op_t  cmd;
        logic [7:0] operand;
        logic [7:0] accumulator;
        logic [7:0] index_x;
        logic [7:0] index_y;
        logic       carry_in;
        logic       decimal_flag;
    } ebalu_req_t;

    // response payload
    typedef struct packed {
        logic [7:0] result;
        logic       carry_out;
        logic       carry_written;
        logic       overflow_out;
        logic       overflow_written;
        logic       zero_out;
        logic       negative_out;
    } ebalu_rsp_t;

    // bcd correction constants
    localparam logic [5:0] BCD_NIB_MAX   = 6'h09;
    localparam logic [5:0] BCD_NIB_FIX   = 6'h06;
    localparam logic [5:0] NIB_LIMIT     = 6'h0f;
    localparam logic [9:0] BCD_BYTE_MAX  = 10'h09f;
    localparam logic [9:0] BCD_BYTE_FIX  = 10'h060;
    localparam logic [9:0] BYTE_LIMIT    = 10'h0ff;
    localparam logic       DEC_EN_RESET  = 1'b1;

endpackage

`default_nettype wire

// File: src/eight_bit_alu_with_decimal_mode.sv
`default_nettype none

// Eight-bit ALU with BCD add and subtract.
// Request channel: drive request and pulse start; a transfer happens at a
// rising edge with start high and busy low. busy stays low, so a new
// request may be presented in every cycle.
// Response channel: done is high for exactly one cycle while response holds
// the result; the receiver takes it in that cycle and cannot stall it.
// The accepting edge loads the request register, the next loads the
// response register. Throughput is one operation per cycle, set by the
// single adder/logic stage between those two registers.
// Configuration channel: cfg_valid/cfg_ready/cfg_data write the decimal
// enable bit; cfg_ready is always high. Write it only while no request is
// in flight. With decimal enable at 0, ADC and SBC are always binary.
// Reset (rst_n low, asynchronous) clears the pipeline valid bits, so no
// done pulse follows reset, and sets decimal enable to 1.
module eight_bit_alu_with_decimal_mode
    import ebalu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire ebalu_req_t request,
    output logic            done,
    output ebalu_rsp_t      response,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data
);

    logic       dec_en_reg;
    logic       req_valid_reg;
    ebalu_req_t req_reg;
    logic       req_dec_reg;
    logic       done_reg;
    ebalu_rsp_t rsp_reg;
    ebalu_rsp_t rsp_next;

    logic [7:0] a;
    logic [7:0] m;
    logic [7:0] addend;
    logic       sub;
    logic [8:0] bin_sum;
    logic       bin_ovf;
    logic [5:0] lo_raw;
    logic [5:0] lo_adj;
    logic       nib_carry;
    logic [9:0] hi_raw;
    logic [9:0] hi_adj;
    logic [7:0] cmp_reg_val;
    logic [8:0] cmp_diff;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign response  = rsp_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_en_reg <= DEC_EN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dec_en_reg <= cfg_data;
        end
    end

    // request stage valid and response strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
        end
    end

    // request payload capture
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg     <= request;
            req_dec_reg <= dec_en_reg && request.decimal_flag;
        end
    end

    // shared adder operands
    assign a      = req_reg.accumulator;
    assign m      = req_reg.operand;
    assign sub    = (req_reg.cmd == OP_SBC);
    assign addend = sub ? ~m : m;

    // binary add with carry
    assign bin_sum = {1'b0, a} + {1'b0, addend} + {8'd0, req_reg.carry_in};
    assign bin_ovf = ~(a[7] ^ addend[7]) & (a[7] ^ bin_sum[7]);

    // bcd low nibble with correction
    assign lo_raw = {2'b00, a[3:0]} + {2'b00, addend[3:0]} + {5'd0, req_reg.carry_in};

    always_comb
    begin
        if (sub)
        begin
            lo_adj    = (lo_raw <= NIB_LIMIT) ? (lo_raw - BCD_NIB_FIX) : lo_raw;
            nib_carry = (lo_raw > NIB_LIMIT);
        end
        else
        begin
            lo_adj    = (lo_raw > BCD_NIB_MAX) ? (lo_raw + BCD_NIB_FIX) : lo_raw;
            nib_carry = (lo_adj > NIB_LIMIT);
        end
    end

    // bcd high part with correction, kept modulo 2^10 (bit 8 is the carry)
    assign hi_raw = {2'b00, a[7:4], 4'h0} + {2'b00, addend[7:4], 4'h0}
                  + {5'd0, nib_carry, 4'h0} + {6'd0, lo_adj[3:0]};

    always_comb
    begin
        if (sub)
        begin
            hi_adj = (hi_raw <= BYTE_LIMIT) ? (hi_raw - BCD_BYTE_FIX) : hi_raw;
        end
        else
        begin
            hi_adj = (hi_raw > BCD_BYTE_MAX) ? (hi_raw + BCD_BYTE_FIX) : hi_raw;
        end
    end

    // compare subtractor
    always_comb
    begin
        unique case (req_reg.cmd)
            OP_CPX:  cmp_reg_val = req_reg.index_x;
            OP_CPY:  cmp_reg_val = req_reg.index_y;
            default: cmp_reg_val = a;
        endcase
    end

    assign cmp_diff = {1'b0, cmp_reg_val} - {1'b0, m};

    // result and flag select
    always_comb
    begin
        rsp_next = '0;
        unique case (req_reg.cmd)
            OP_ADC, OP_SBC:
            begin
                if (req_dec_reg)
                begin
                    rsp_next.result        = hi_adj[7:0];
                    rsp_next.carry_out     = hi_adj[8];
                    rsp_next.carry_written = 1'b1;
                end
                else
                begin
                    rsp_next.result           = bin_sum[7:0];
                    rsp_next.carry_out        = bin_sum[8];
                    rsp_next.carry_written    = 1'b1;
                    rsp_next.overflow_out     = bin_ovf;
                    rsp_next.overflow_written = 1'b1;
                end
            end
            OP_AND: rsp_next.result = a & m;
            OP_ASL:
            begin
                rsp_next.result        = {m[6:0], 1'b0};
                rsp_next.carry_out     = m[7];
                rsp_next.carry_written = 1'b1;
            end
            OP_BIT:
            begin
                rsp_next.result           = a;
                rsp_next.overflow_out     = m[6];
                rsp_next.overflow_written = 1'b1;
            end
            OP_CMP, OP_CPX, OP_CPY:
            begin
                rsp_next.result        = cmp_reg_val;
                rsp_next.carry_out     = ~cmp_diff[8];
                rsp_next.carry_written = 1'b1;
            end
            OP_DEC: rsp_next.result = m - 8'd1;
            OP_EOR: rsp_next.result = a ^ m;
            OP_INC: rsp_next.result = m + 8'd1;
            OP_LD:  rsp_next.result = m;
            OP_LSR:
            begin
                rsp_next.result        = {1'b0, m[7:1]};
                rsp_next.carry_out     = m[0];
                rsp_next.carry_written = 1'b1;
            end
            OP_ORA: rsp_next.result = a | m;
            OP_ROL:
            begin
                rsp_next.result        = {m[6:0], req_reg.carry_in};
                rsp_next.carry_out     = m[7];
                rsp_next.carry_written = 1'b1;
            end
            OP_ROR:
            begin
                rsp_next.result        = {req_reg.carry_in, m[7:1]};
                rsp_next.carry_out     = m[0];
                rsp_next.carry_written = 1'b1;
            end
            default: rsp_next.result = m;
        endcase

        // zero and negative come from the result, except for bit test and compares
        priority if (req_reg.cmd == OP_BIT)
        begin
            rsp_next.zero_out     = ((a & m) == 8'd0);
            rsp_next.negative_out = m[7];
        end
        else if (req_reg.cmd == OP_CMP || req_reg.cmd == OP_CPX || req_reg.cmd == OP_CPY)
        begin
            rsp_next.zero_out     = (cmp_diff[7:0] == 8'd0);
            rsp_next.negative_out = cmp_diff[7];
        end
        else
        begin
            rsp_next.zero_out     = (rsp_next.result == 8'd0);
            rsp_next.negative_out = rsp_next.result[7];
        end
    end

    // response register
    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef NO_ASSERTIONS
    // every response comes from an earlier transfer, through the request and response registers
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("response without matching request");

    // a flag that is not written reads as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !response.carry_written |-> !response.carry_out)
        else $error("carry set while not written");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && !response.overflow_written |-> !response.overflow_out)
        else $error("overflow set while not written");

    // overflow is never written by a decimal add or subtract
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && req_dec_reg && (req_reg.cmd == OP_ADC || req_reg.cmd == OP_SBC)
        |=> !response.overflow_written)
        else $error("overflow written in decimal mode");

    // configuration transfer lands in the enable register
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> dec_en_reg == $past(cfg_data))
        else $error("decimal enable write lost");
`endif

endmodule

`default_nettype wire

// File: bench/testbench.sv
module testbench;
    import ebalu_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    ebalu_req_t request;
    logic       done;
    ebalu_rsp_t response;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;

    ebalu_rsp_t pending_responses[$];
    logic       decimal_enable_copy;
    int         fail_count;
    int         sender_idle_pct;

    eight_bit_alu_with_decimal_mode dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    // expected alu response for one operation
    function automatic ebalu_rsp_t compute_alu_response(input ebalu_req_t rq,
                                                        input logic dec_en);
        ebalu_rsp_t  rs;
        logic [7:0]  addend;
        logic [8:0]  bin_sum;
        logic [8:0]  diff;
        logic [7:0]  cmp_reg;
        logic [15:0] wide;
        logic        use_bcd;
        int          nib;
        int          full;
        rs = '0;
        use_bcd = dec_en & rq.decimal_flag;
        cmp_reg = rq.accumulator;
        case (rq.cmd)
            OP_ADC, OP_SBC:
            begin
                addend = (rq.cmd == OP_SBC) ? ~rq.operand : rq.operand;
                rs.carry_written = 1'b1;
                if (!use_bcd)
                begin
                    bin_sum = {1'b0, rq.accumulator} + {1'b0, addend} + {8'd0, rq.carry_in};
                    rs.result = bin_sum[7:0];
                    rs.carry_out = bin_sum[8];
                    rs.overflow_out = ~(rq.accumulator[7] ^ addend[7])
                                      & (rq.accumulator[7] ^ bin_sum[7]);
                    rs.overflow_written = 1'b1;
                end
                else
                begin
                    // low nibble with decimal adjust, then the high part
                    nib = int'(rq.accumulator & 8'h0f) + int'(addend & 8'h0f)
                          + int'(rq.carry_in);
                    if (rq.cmd == OP_ADC)
                    begin
                        if (nib > 9)
                            nib = nib + 6;
                    end
                    else
                    begin
                        if (nib <= 15)
                            nib = nib - 6;
                    end
                    full = int'(rq.accumulator & 8'hf0) + int'(addend & 8'hf0)
                           + ((nib > 15) ? 16 : 0) + (nib & 15);
                    if (rq.cmd == OP_ADC)
                    begin
                        if (full > 'h9f)
                            full = full + 'h60;
                    end
                    else
                    begin
                        if (full <= 'hff)
                            full = full - 'h60;
                    end
                    wide = full[15:0];
                    rs.result = wide[7:0];
                    rs.carry_out = wide[8];
                end
            end
            OP_AND: rs.result = rq.accumulator & rq.operand;
            OP_EOR: rs.result = rq.accumulator ^ rq.operand;
            OP_ORA: rs.result = rq.accumulator | rq.operand;
            OP_DEC: rs.result = rq.operand - 8'd1;
            OP_INC: rs.result = rq.operand + 8'd1;
            OP_LD:  rs.result = rq.operand;
            OP_ASL:
            begin
                rs.result = {rq.operand[6:0], 1'b0};
                rs.carry_out = rq.operand[7];
                rs.carry_written = 1'b1;
            end
            OP_LSR:
            begin
                rs.result = {1'b0, rq.operand[7:1]};
                rs.carry_out = rq.operand[0];
                rs.carry_written = 1'b1;
            end
            OP_ROL:
            begin
                rs.result = {rq.operand[6:0], rq.carry_in};
                rs.carry_out = rq.operand[7];
                rs.carry_written = 1'b1;
            end
            OP_ROR:
            begin
                rs.result = {rq.carry_in, rq.operand[7:1]};
                rs.carry_out = rq.operand[0];
                rs.carry_written = 1'b1;
            end
            default: ;
        endcase
        rs.zero_out = (rs.result == 8'd0);
        rs.negative_out = rs.result[7];
        // bit test and compares set zero and negative their own way
        if (rq.cmd == OP_BIT)
        begin
            rs.result = rq.accumulator;
            rs.overflow_out = rq.operand[6];
            rs.overflow_written = 1'b1;
            rs.zero_out = ((rq.accumulator & rq.operand) == 8'd0);
            rs.negative_out = rq.operand[7];
        end
        else if (rq.cmd == OP_CMP || rq.cmd == OP_CPX || rq.cmd == OP_CPY)
        begin
            if (rq.cmd == OP_CPX)
                cmp_reg = rq.index_x;
            else if (rq.cmd == OP_CPY)
                cmp_reg = rq.index_y;
            diff = {1'b0, cmp_reg} - {1'b0, rq.operand};
            rs.result = cmp_reg;
            rs.carry_out = ~diff[8];
            rs.carry_written = 1'b1;
            rs.zero_out = (diff[7:0] == 8'd0);
            rs.negative_out = diff[7];
        end
        return rs;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
            note_failure($sformatf("mismatch on %s: expected %02h, got %02h",
                                   field, want, got));
    endtask

    // result checking and capture of accepted operations and register writes
    always @(posedge clk)
    begin
        ebalu_rsp_t want;
        if (!rst_n)
        begin
            decimal_enable_copy <= DEC_EN_RESET;
        end
        else
        begin
            if (done)
            begin
                if (pending_responses.size() == 0)
                begin
                    note_failure("result with no operation outstanding");
                end
                else
                begin
                    want = pending_responses.pop_front();
                    check_field("result", want.result, response.result);
                    check_field("carry_out", {7'd0, want.carry_out},
                                {7'd0, response.carry_out});
                    check_field("carry_written", {7'd0, want.carry_written},
                                {7'd0, response.carry_written});
                    check_field("overflow_out", {7'd0, want.overflow_out},
                                {7'd0, response.overflow_out});
                    check_field("overflow_written", {7'd0, want.overflow_written},
                                {7'd0, response.overflow_written});
                    check_field("zero_out", {7'd0, want.zero_out},
                                {7'd0, response.zero_out});
                    check_field("negative_out", {7'd0, want.negative_out},
                                {7'd0, response.negative_out});
                end
            end
            if (start && !busy)
                pending_responses.push_back(compute_alu_response(request,
                                                                 decimal_enable_copy));
            if (cfg_valid && cfg_ready)
                decimal_enable_copy <= cfg_data;
        end
    end

    // one operation transfer, with random idle cycles before it
    task automatic send_item(input ebalu_req_t item);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_for_responses();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_responses.size() != 0);
    endtask

    task automatic write_decimal_enable(input logic value);
        wait_for_responses();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic ebalu_req_t make_req(input ebalu_op_t op, input logic [7:0] m,
                                            input logic [7:0] a, input logic [7:0] x,
                                            input logic [7:0] y, input logic c,
                                            input logic d);
        ebalu_req_t rq;
        rq.cmd = op;
        rq.operand = m;
        rq.accumulator = a;
        rq.index_x = x;
        rq.index_y = y;
        rq.carry_in = c;
        rq.decimal_flag = d;
        return rq;
    endfunction

    // byte biased toward edge values and valid decimal digits
    function automatic logic [7:0] pick_byte();
        logic [7:0] edges[9] = '{8'h00, 8'hff, 8'h7f, 8'h80, 8'h01, 8'hfe,
                                 8'h99, 8'h0f, 8'hf0};
        int         sel;
        sel = $urandom_range(9);
        if (sel < 2)
            return edges[$urandom_range(8)];
        else if (sel < 5)
            return {4'($urandom_range(9)), 4'($urandom_range(9))};
        else
            return 8'($urandom);
    endfunction

    // logic, shift, increment, decrement, load, bit test and compare edge cases
    task automatic test_flag_ops();
        send_item(make_req(OP_AND, 8'h00, 8'hff, 8'h00, 8'h00, 1'b0, 1'b0));
        send_item(make_req(OP_ASL, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        send_item(make_req(OP_BIT, 8'hc0, 8'h3f, 8'h00, 8'h00, 1'b1, 1'b0));
        send_item(make_req(OP_CMP, 8'h40, 8'h40, 8'h00, 8'h00, 1'b0, 1'b0));
        send_item(make_req(OP_CPX, 8'hff, 8'h00, 8'h00, 8'hff, 1'b1, 1'b1));
        send_item(make_req(OP_CPY, 8'h00, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0));
        send_item(make_req(OP_DEC, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        send_item(make_req(OP_EOR, 8'h55, 8'haa, 8'h00, 8'h00, 1'b0, 1'b0));
        send_item(make_req(OP_INC, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
        send_item(make_req(OP_LD, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        send_item(make_req(OP_LSR, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
        send_item(make_req(OP_ORA, 8'h00, 8'h00, 8'hff, 8'hff, 1'b0, 1'b1));
        send_item(make_req(OP_ROL, 8'h80, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
        send_item(make_req(OP_ROR, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
    endtask

    // decimal and binary add and subtract, including invalid digits
    task automatic test_add_sub();
        send_item(make_req(OP_ADC, 8'h01, 8'h99, 8'h00, 8'h00, 1'b0, 1'b1));
        send_item(make_req(OP_ADC, 8'h46, 8'h58, 8'h00, 8'h00, 1'b1, 1'b1));
        send_item(make_req(OP_ADC, 8'hff, 8'hff, 8'h00, 8'h00, 1'b1, 1'b1));
        send_item(make_req(OP_SBC, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        send_item(make_req(OP_SBC, 8'h12, 8'h46, 8'h00, 8'h00, 1'b1, 1'b1));
        send_item(make_req(OP_SBC, 8'hff, 8'h0f, 8'h00, 8'h00, 1'b0, 1'b1));
        send_item(make_req(OP_ADC, 8'h01, 8'h7f, 8'h00, 8'h00, 1'b0, 1'b0));
        send_item(make_req(OP_SBC, 8'h01, 8'h80, 8'h00, 8'h00, 1'b1, 1'b0));
    endtask

    // decimal flag is ignored while decimal mode is disabled
    task automatic test_decimal_disable();
        write_decimal_enable(1'b0);
        send_item(make_req(OP_ADC, 8'h01, 8'h99, 8'h00, 8'h00, 1'b0, 1'b1));
        send_item(make_req(OP_SBC, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        write_decimal_enable(1'b1);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct);
        sender_idle_pct = idle_pct;
        repeat (count)
            send_item(make_req(ebalu_op_t'($urandom_range(15)), pick_byte(),
                               pick_byte(), pick_byte(), pick_byte(),
                               1'($urandom), 1'($urandom)));
    endtask

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        fail_count = 0;
        sender_idle_pct = 26;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_flag_ops();
        test_add_sub();
        test_decimal_disable();
        test_random_traffic(280, 26);
        write_decimal_enable(1'b0);
        test_random_traffic(280, 68);
        write_decimal_enable(1'b1);
        test_random_traffic(290, 0);

        // drain, then allow the pipeline latency to pass
        wait_for_responses();
        repeat (4)
            @(posedge clk);
        if (fail_count == 0 && pending_responses.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
